// File: sv/dts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dts_pkg;

  localparam int MAX_TASKS    = 16;
  localparam int PERIOD_WIDTH = 16;
  localparam int DL_W         = PERIOD_WIDTH + 1;
  localparam int IDX_W        = $clog2(MAX_TASKS);
  localparam int ID_W         = 4;
  localparam int CODE_W       = 5;
  localparam int CNT_W        = 5;
  localparam int REQ_W        = 3;

  localparam logic [CODE_W-1:0] IDLE_CODE = CODE_W'(MAX_TASKS);
  localparam logic [DL_W-1:0]   NO_DEADLINE = {DL_W{1'b1}};

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD    = 3'd0,
    REQ_UNBLOCK = 3'd1,
    REQ_TICK    = 3'd2,
    REQ_EXIT    = 3'd3,
    REQ_BLOCK   = 3'd4,
    REQ_DEFINE  = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DELIVER
  } state_t;

  // table update broadcast to every cell
  typedef struct packed {
    logic                    set_rdy;
    logic                    define;
    logic [PERIOD_WIDTH-1:0] period;
    logic                    drop;
    logic                    drop_dl;
    logic [IDX_W-1:0]        cur;
    logic [ID_W-1:0]         id;
  } cmd_t;

  // best candidate so far, handed from cell to cell
  typedef struct packed {
    logic            found_ap;
    logic            found_per;
    logic [IDX_W-1:0] idx;
    logic [DL_W-1:0] dl;
  } cand_t;

endpackage
`default_nettype wire

// File: sv/dts_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module dts_cell (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [dts_pkg::IDX_W-1:0] index,
  input  wire logic [dts_pkg::CNT_W-1:0] active_count,
  input  wire dts_pkg::cmd_t             cmd,
  input  wire logic                      cand_in_vld,
  input  wire dts_pkg::cand_t            cand_in,
  output logic                           cand_out_vld,
  output dts_pkg::cand_t                 cand_out,
  output logic                           aper
);

  logic                      ready;
  logic [dts_pkg::DL_W-1:0]  dl;
  logic                      own_rdy;
  logic                      hit_id;
  logic                      hit_cur;
  dts_pkg::cand_t            cand_next;

  assign hit_id  = (cmd.id == dts_pkg::ID_W'(index));
  assign hit_cur = (cmd.cur == index);
  assign own_rdy = ready && (dts_pkg::CNT_W'(index) < active_count);

  // ready bit
  always_ff @(posedge clk) begin
    if (rst) begin
      ready <= 1'b0;
    end else if (cmd.set_rdy && hit_id) begin
      ready <= 1'b1;
    end else if (cmd.drop && hit_cur) begin
      ready <= 1'b0;
    end
  end

  // aperiodic flag and deadline
  always_ff @(posedge clk) begin
    if (cmd.define && hit_id) begin
      if (cmd.period == '0) begin
        aper <= 1'b1;
        dl   <= dts_pkg::NO_DEADLINE;
      end else begin
        aper <= 1'b0;
        dl   <= {1'b0, cmd.period};
      end
    end else if (cmd.drop && cmd.drop_dl && hit_cur && !aper) begin
      dl <= dts_pkg::NO_DEADLINE;
    end
  end

  // merge own entry into the passing candidate
  always_comb begin
    cand_next = cand_in;
    if (!cand_in.found_ap && own_rdy) begin
      if (aper) begin
        cand_next.found_ap  = 1'b1;
        cand_next.found_per = 1'b0;
        cand_next.idx       = index;
        cand_next.dl        = dl;
      end else if (!cand_in.found_per || ($signed(dl) < $signed(cand_in.dl))) begin
        cand_next.found_ap  = 1'b0;
        cand_next.found_per = 1'b1;
        cand_next.idx       = index;
        cand_next.dl        = dl;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_out_vld <= 1'b0;
    end else begin
      cand_out_vld <= cand_in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (cand_in_vld) begin
      cand_out <= cand_next;
    end
  end

endmodule
`default_nettype wire

// File: sv/deadline_task_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  bits  contents
// s_axis    in   32+3  request word: task_id, current_task, period_value; tuser req_type
// m_axis    out  8     next_task
// cfg       in   5     task_count, written when cfg_we is high
//
// Load, unblock and define give no word. Exit, block and a tick on a periodic,
// idle or out-of-range task launch a scan wave down the row of task cells, one
// cell per cycle, whose result goes to the output register. A tick that keeps an
// aperiodic task skips the scan and goes straight to the deliver state.
// Reset clears all ready bits and sets task_count to 16. A stalled m_axis holds
// its word; the next request is taken once the result has moved into it.
module deadline_task_scheduler (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  // [3:0] task_id, [8:4] current_task, [24:9] period_value
  input  wire logic [31:0]               s_axis_tdata,
  // [2:0] req_type
  input  wire logic [dts_pkg::REQ_W-1:0] s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  // [4:0] next_task
  output logic [7:0]                     m_axis_tdata,
  input  wire logic                      cfg_we,
  input  wire logic [dts_pkg::CNT_W-1:0] cfg_wdata
);

  dts_pkg::state_t                state;
  dts_pkg::state_t                state_next;
  logic [dts_pkg::CNT_W-1:0]      task_count;
  logic [dts_pkg::CNT_W-1:0]      active_count;
  logic                           launch;
  logic [dts_pkg::CODE_W-1:0]     res;
  logic                           load_out;

  dts_pkg::req_t                  req;
  logic [dts_pkg::ID_W-1:0]       task_id;
  logic [dts_pkg::CODE_W-1:0]     cur;
  logic [dts_pkg::PERIOD_WIDTH-1:0] period;
  logic                           accept;
  logic                           is_sched;
  logic                           cur_valid;
  logic                           keep;
  dts_pkg::cmd_t                  cmd;

  logic                           vld  [dts_pkg::MAX_TASKS+1];
  dts_pkg::cand_t                 cand [dts_pkg::MAX_TASKS+1];
  logic [dts_pkg::MAX_TASKS-1:0]  aper_vec;
  logic                           scan_done;
  dts_pkg::cand_t                 scan_res;

  // request word fields
  assign req     = dts_pkg::req_t'(s_axis_tuser);
  assign task_id = s_axis_tdata[3:0];
  assign cur     = s_axis_tdata[8:4];
  assign period  = s_axis_tdata[24:9];
  assign accept  = s_axis_tvalid && s_axis_tready;

  assign active_count = (task_count > dts_pkg::CNT_W'(dts_pkg::MAX_TASKS))
                        ? dts_pkg::CNT_W'(dts_pkg::MAX_TASKS) : task_count;
  assign cur_valid = (cur != dts_pkg::IDLE_CODE) &&
                     (dts_pkg::CNT_W'(cur) < active_count);
  assign keep = cur_valid && aper_vec[cur[dts_pkg::IDX_W-1:0]];

  // decode request into table command
  always_comb begin
    cmd         = '0;
    cmd.period  = period;
    cmd.cur     = cur[dts_pkg::IDX_W-1:0];
    cmd.id      = task_id;
    is_sched    = 1'b0;
    case (req)
      dts_pkg::REQ_LOAD, dts_pkg::REQ_UNBLOCK: begin
        cmd.set_rdy = accept;
      end
      dts_pkg::REQ_DEFINE: begin
        cmd.define = accept;
      end
      dts_pkg::REQ_TICK: begin
        is_sched = 1'b1;
      end
      dts_pkg::REQ_EXIT: begin
        is_sched    = 1'b1;
        cmd.drop    = accept && cur_valid;
        cmd.drop_dl = 1'b1;
      end
      dts_pkg::REQ_BLOCK: begin
        is_sched = 1'b1;
        cmd.drop = accept && cur_valid;
      end
      default: begin
        is_sched = 1'b0;
      end
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      task_count <= dts_pkg::CNT_W'(16);
    end else if (cfg_we) begin
      task_count <= cfg_wdata;
    end
  end

  // row of task cells, the scan wave enters at cell 0
  assign vld[0]  = launch;
  assign cand[0] = '0;

  for (genvar i = 0; i < dts_pkg::MAX_TASKS; i++) begin : g_cell
    dts_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .index        (dts_pkg::IDX_W'(i)),
      .active_count (active_count),
      .cmd          (cmd),
      .cand_in_vld  (vld[i]),
      .cand_in      (cand[i]),
      .cand_out_vld (vld[i+1]),
      .cand_out     (cand[i+1]),
      .aper         (aper_vec[i])
    );
  end

  assign scan_done = vld[dts_pkg::MAX_TASKS];
  assign scan_res  = cand[dts_pkg::MAX_TASKS];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      dts_pkg::ST_IDLE: begin
        if (accept && is_sched) begin
          state_next = keep && (req == dts_pkg::REQ_TICK)
                       ? dts_pkg::ST_DELIVER : dts_pkg::ST_SCAN;
        end
      end
      dts_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_next = dts_pkg::ST_DELIVER;
        end
      end
      dts_pkg::ST_DELIVER: begin
        if (load_out) begin
          state_next = dts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dts_pkg::ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    case (state)
      dts_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      dts_pkg::ST_DELIVER: begin
        load_out = !m_axis_tvalid || m_axis_tready;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= dts_pkg::ST_IDLE;
      launch <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= accept && is_sched && !(keep && (req == dts_pkg::REQ_TICK));
    end
  end

  // held result
  always_ff @(posedge clk) begin
    if (state == dts_pkg::ST_IDLE && accept) begin
      res <= cur;
    end else if (state == dts_pkg::ST_SCAN && scan_done) begin
      res <= (scan_res.found_ap || scan_res.found_per)
             ? dts_pkg::CODE_W'(scan_res.idx) : dts_pkg::IDLE_CODE;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tdata <= {(8 - dts_pkg::CODE_W)'(0), res};
    end
  end

endmodule
`default_nettype wire

// File: test/deadline_task_scheduler_test.sv
`timescale 1ns / 1ps
module deadline_task_scheduler_test;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = dts_pkg::MAX_TASKS + 8;
  localparam int HOLD_CYCLES  = 300;

  // request codes outside the defined set, ignored by the block
  localparam logic [dts_pkg::REQ_W-1:0] REQ_SPARE_6 = 3'd6;
  localparam logic [dts_pkg::REQ_W-1:0] REQ_SPARE_7 = 3'd7;

  logic                        clk           = 1'b0;
  logic                        rst           = 1'b1;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  // [3:0] task_id, [8:4] current_task, [24:9] period_value
  logic [31:0]                 s_axis_tdata  = '0;
  // [2:0] req_type
  logic [dts_pkg::REQ_W-1:0]   s_axis_tuser  = '0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  // [4:0] next_task
  logic [7:0]                  m_axis_tdata;
  logic                        cfg_we        = 1'b0;
  logic [dts_pkg::CNT_W-1:0]   cfg_wdata     = '0;

  // scheduler state as the testbench sees it
  logic                            ready_m [dts_pkg::MAX_TASKS];
  logic                            aper_m  [dts_pkg::MAX_TASKS];
  logic signed [dts_pkg::DL_W-1:0] dl_m    [dts_pkg::MAX_TASKS];
  logic [dts_pkg::CNT_W-1:0]       count_m;
  logic [dts_pkg::CODE_W-1:0]      running_m;
  logic [dts_pkg::CODE_W-1:0]      pending_next [$];

  int errors         = 0;
  int words_checked  = 0;
  int requests_sent  = 0;
  int cfg_writes     = 0;
  int cycles         = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;

  deadline_task_scheduler DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int active_tasks();
    return (count_m > dts_pkg::MAX_TASKS) ? dts_pkg::MAX_TASKS : int'(count_m);
  endfunction

  // aperiodic first by index, then earliest deadline, ties to the lower index
  function automatic logic [dts_pkg::CODE_W-1:0] pick_ready_task();
    int n;
    int best;
    n = active_tasks();
    best = -1;
    for (int i = 0; i < n; i++)
      if (aper_m[i] && ready_m[i]) return dts_pkg::CODE_W'(i);
    for (int i = 0; i < n; i++)
      if (!aper_m[i] && ready_m[i] && (best < 0 || dl_m[i] < dl_m[best])) best = i;
    return (best < 0) ? dts_pkg::IDLE_CODE : dts_pkg::CODE_W'(best);
  endfunction

  // update the table for one request; returns 1 when a next_task word follows
  function automatic bit apply_request(input logic [dts_pkg::REQ_W-1:0] req,
                                       input logic [dts_pkg::ID_W-1:0] id,
                                       input logic [dts_pkg::CODE_W-1:0] cur,
                                       input logic [dts_pkg::PERIOD_WIDTH-1:0] period,
                                       output logic [dts_pkg::CODE_W-1:0] next_code);
    bit cur_ok;
    cur_ok = (cur != dts_pkg::IDLE_CODE) && (cur < active_tasks());
    next_code = dts_pkg::IDLE_CODE;
    case (req)
      dts_pkg::REQ_LOAD, dts_pkg::REQ_UNBLOCK: begin
        ready_m[id] = 1'b1;
        return 1'b0;
      end
      dts_pkg::REQ_DEFINE: begin
        aper_m[id] = (period == '0);
        dl_m[id] = (period == '0) ? dts_pkg::NO_DEADLINE : {1'b0, period};
        return 1'b0;
      end
      dts_pkg::REQ_TICK: begin
        next_code = (cur_ok && aper_m[cur]) ? cur : pick_ready_task();
      end
      dts_pkg::REQ_EXIT: begin
        if (cur_ok) begin
          ready_m[cur] = 1'b0;
          if (!aper_m[cur]) dl_m[cur] = dts_pkg::NO_DEADLINE;
        end
        next_code = pick_ready_task();
      end
      dts_pkg::REQ_BLOCK: begin
        if (cur_ok) ready_m[cur] = 1'b0;
        next_code = pick_ready_task();
      end
      default: begin
        return 1'b0;
      end
    endcase
    return 1'b1;
  endfunction

  // offer one request word; entered and left just after a falling edge
  task automatic send_request(input logic [dts_pkg::REQ_W-1:0] req,
                              input logic [dts_pkg::ID_W-1:0] id,
                              input logic [dts_pkg::CODE_W-1:0] cur,
                              input logic [dts_pkg::PERIOD_WIDTH-1:0] period);
    logic [dts_pkg::CODE_W-1:0] next_code;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, period, cur, id};
    s_axis_tuser  <= req;
    do @(posedge clk); while (!s_axis_tready);
    if (apply_request(req, id, cur, period, next_code)) begin
      pending_next.push_back(next_code);
      running_m = next_code;
    end
    requests_sent++;
    @(negedge clk);
  endtask

  // stop offering and let every outstanding word and the scan wave finish
  task automatic wait_for_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_next.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_task_count(input logic [dts_pkg::CNT_W-1:0] value);
    wait_for_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    count_m = value;
    cfg_writes++;
  endtask

  // mostly the running task as current, ids biased into the active table
  task automatic send_random_request();
    logic [dts_pkg::REQ_W-1:0]        req;
    logic [dts_pkg::ID_W-1:0]         id;
    logic [dts_pkg::CODE_W-1:0]       cur;
    logic [dts_pkg::PERIOD_WIDTH-1:0] period;
    int pick;
    int n;
    n = active_tasks();
    pick = $urandom_range(99);
    if (pick < 20) req = dts_pkg::REQ_LOAD;
    else if (pick < 35) req = dts_pkg::REQ_UNBLOCK;
    else if (pick < 60) req = dts_pkg::REQ_TICK;
    else if (pick < 75) req = dts_pkg::REQ_EXIT;
    else if (pick < 87) req = dts_pkg::REQ_BLOCK;
    else req = dts_pkg::REQ_DEFINE;
    id = (n > 0 && $urandom_range(3) != 0) ? dts_pkg::ID_W'($urandom_range(n - 1))
                                           : dts_pkg::ID_W'($urandom);
    cur = ($urandom_range(4) != 0) ? running_m
                                   : dts_pkg::CODE_W'($urandom_range(dts_pkg::MAX_TASKS));
    pick = $urandom_range(99);
    if (pick < 15) period = '0;
    else if (pick < 65) period = dts_pkg::PERIOD_WIDTH'($urandom_range(8, 1));
    else if (pick < 70) period = '1;
    else period = dts_pkg::PERIOD_WIDTH'($urandom);
    send_request(req, id, cur, period);
  endtask

  // every entry defined up front so no undefined entry is ever read
  task automatic test_define_table();
    logic [dts_pkg::PERIOD_WIDTH-1:0] p;
    for (int i = 0; i < dts_pkg::MAX_TASKS; i++) begin
      if (i == 3 || i == 9) p = '0;
      else if (i == 0) p = '1;
      else if (i < 3) p = dts_pkg::PERIOD_WIDTH'(1);
      else p = dts_pkg::PERIOD_WIDTH'(100 + i);
      send_request(dts_pkg::REQ_DEFINE, dts_pkg::ID_W'(i), dts_pkg::IDLE_CODE, p);
    end
  endtask

  // tasks 3 and 9 aperiodic, 1 and 2 share the shortest period
  task automatic test_directed_sequence();
    send_request(dts_pkg::REQ_TICK,    4'd0, dts_pkg::IDLE_CODE, '0);   // nothing ready
    send_request(dts_pkg::REQ_LOAD,    4'd0, dts_pkg::IDLE_CODE, '0);
    send_request(dts_pkg::REQ_LOAD,    4'd2, dts_pkg::IDLE_CODE, '0);
    send_request(dts_pkg::REQ_UNBLOCK, 4'd1, dts_pkg::IDLE_CODE, '0);
    send_request(dts_pkg::REQ_TICK,    4'd0, dts_pkg::IDLE_CODE, '0);   // deadline tie
    send_request(dts_pkg::REQ_UNBLOCK, 4'd9, dts_pkg::IDLE_CODE, '0);
    send_request(dts_pkg::REQ_TICK,    4'd0, 5'd1, '0);        // aperiodic goes first
    send_request(dts_pkg::REQ_LOAD,    4'd3, dts_pkg::IDLE_CODE, '0);
    send_request(dts_pkg::REQ_TICK,    4'd0, 5'd9, '0);        // aperiodic kept
    send_request(dts_pkg::REQ_BLOCK,   4'd0, 5'd9, '0);
    send_request(dts_pkg::REQ_TICK,    4'd0, 5'd9, '0);        // kept though blocked
    send_request(dts_pkg::REQ_EXIT,    4'd0, 5'd3, '0);        // aperiodic exit
    send_request(dts_pkg::REQ_EXIT,    4'd0, 5'd1, '0);        // periodic exit drops deadline
    send_request(dts_pkg::REQ_LOAD,    4'd1, dts_pkg::IDLE_CODE, '0);
    send_request(dts_pkg::REQ_TICK,    4'd0, 5'd2, '0);        // dropped deadline wins
    send_request(dts_pkg::REQ_DEFINE,  4'd1, dts_pkg::IDLE_CODE, '1);   // ready bit untouched
    send_request(dts_pkg::REQ_TICK,    4'd0, dts_pkg::IDLE_CODE, '0);
    send_request(REQ_SPARE_6,          4'hF, 5'd0, '1);
    send_request(REQ_SPARE_7,          4'hF, 5'd0, '1);
    send_request(dts_pkg::REQ_BLOCK,   4'd0, dts_pkg::IDLE_CODE, '0);   // idle current
    send_request(dts_pkg::REQ_EXIT,    4'd0, 5'd0, '1);
  endtask

  // table sizes incl. empty, single entry and values beyond the table
  task automatic test_task_count_settings();
    logic [dts_pkg::CNT_W-1:0] counts [6] = '{5'd4, 5'd1, 5'd0, 5'd31, 5'd17, 5'd16};
    for (int k = 0; k < 6; k++) begin
      write_task_count(counts[k]);
      repeat (30) send_random_request();
    end
  endtask

  // receiver holds off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = HOLD_CYCLES;
    repeat (40) send_random_request();
  endtask

  // four idle patterns, table size varied between them
  task automatic test_random_traffic();
    int send_pcts [4] = '{0, 51, 0, 23};
    int recv_pcts [4] = '{0, 0, 51, 23};
    for (int k = 0; k < 4; k++) begin
      if (k == 0 || k == 3) write_task_count(dts_pkg::CNT_W'(dts_pkg::MAX_TASKS));
      else write_task_count(dts_pkg::CNT_W'($urandom_range(dts_pkg::MAX_TASKS - 1, 2)));
      send_idle_pct  = send_pcts[k];
      recv_stall_pct = recv_pcts[k];
      repeat (190) send_random_request();
    end
  endtask

  // receiver ready, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // compare each next_task word with the oldest prediction
  always @(posedge clk) begin : check_next_task
    logic [dts_pkg::CODE_W-1:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      words_checked++;
      if (pending_next.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, got next_task %0d", $time,
                 m_axis_tdata[dts_pkg::CODE_W-1:0]);
      end else begin
        want = pending_next.pop_front();
        if (m_axis_tdata[dts_pkg::CODE_W-1:0] !== want) begin
          errors++;
          $display("%0t: next_task mismatch, expected %0d, got %0d", $time, want,
                   m_axis_tdata[dts_pkg::CODE_W-1:0]);
        end
      end
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("deadline_task_scheduler_test NOT OK");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < dts_pkg::MAX_TASKS; i++) begin
      ready_m[i] = 1'b0;
      aper_m[i]  = 1'b0;
      dl_m[i]    = '0;
    end
    count_m   = dts_pkg::CNT_W'(dts_pkg::MAX_TASKS);
    running_m = dts_pkg::IDLE_CODE;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_define_table();
    test_directed_sequence();
    test_task_count_settings();
    test_backpressure();
    test_random_traffic();
    wait_for_idle();
    $display("run covered %0d requests, %0d next_task words, %0d table size writes",
             requests_sent, words_checked, cfg_writes);
    $display("idle patterns: none, sender, receiver, both, plus one long receiver hold-off");
    if (errors == 0 && pending_next.size() == 0) begin
      $display("deadline_task_scheduler_test OK");
    end else begin
      $display("deadline_task_scheduler_test NOT OK");
    end
    $finish;
  end

endmodule
